// ===== hw/rtl/ssr_pkg.sv =====
// Shared types and constants for the slot store command responder.
package ssr_pkg;

  // Default configuration of the slot store.
  localparam int SLOT_BYTES_DEF = 256;
  localparam int SLOT_COUNT_DEF = 48;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int LINES_W = 10;
  localparam int DEV_W   = 2;

  // Command codes and answers.
  localparam logic [BYTE_W-1:0] SET_DEV_LO  = 8'h01;
  localparam logic [BYTE_W-1:0] SET_DEV_HI  = 8'h03;
  localparam logic [BYTE_W-1:0] CMD_GET_DEV = 8'h04;
  localparam logic [BYTE_W-1:0] CMD_SYNC    = 8'h0B;
  localparam logic [BYTE_W-1:0] CMD_LINE_LO = 8'h11;
  localparam logic [BYTE_W-1:0] CMD_LINE_HI = 8'h1A;
  localparam logic [BYTE_W-1:0] LOAD_BASE   = 8'h20;
  localparam logic [BYTE_W-1:0] SAVE_BASE   = 8'h50;
  localparam logic [BYTE_W-1:0] SAVE_END    = 8'h80;
  localparam logic [BYTE_W-1:0] ANS_DEV_OK  = 8'h04;
  localparam logic [BYTE_W-1:0] ANS_NEXT    = 8'h0C;
  localparam logic [BYTE_W-1:0] ANS_SYNC    = 8'h0D;
  localparam logic [3:0]        LINE_GROUP  = 4'h1;

  // Transfer mode of the datapath.
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_LOAD = 3'b010,
    MODE_SAVE = 3'b100
  } mode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } ctl_cmd_t;

endpackage

// ===== hw/rtl/ssr_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
module ssr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output ssr_pkg::ctl_cmd_t cmd
);
  import ssr_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  // Next-state logic: capture, execute, respond.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Handshake and datapath commands.
  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = (state_r == ST_RESP);
  assign cmd.capture = (state_r == ST_IDLE) && start;
  assign cmd.exec    = (state_r == ST_EXEC);

endmodule

// ===== hw/rtl/ssr_datapath.sv =====
// Datapath: command decode, mode registers, slot store and result registers.
module ssr_datapath #(
  parameter int SLOT_BYTES = ssr_pkg::SLOT_BYTES_DEF,
  parameter int SLOT_COUNT = ssr_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssr_pkg::ctl_cmd_t            cmd,
  input  logic [ssr_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                         out_send_valid,
  output logic [ssr_pkg::BYTE_W-1:0]   out_send_byte,
  output logic [ssr_pkg::LINES_W-1:0]  out_lines
);
  import ssr_pkg::*;

  localparam int DEPTH  = SLOT_COUNT * SLOT_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(SLOT_BYTES + 1);
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Captured item.
  logic [BYTE_W-1:0]  rx_r;

  // Transfer state.
  mode_t              mode_r, mode_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   cnt_inc;
  logic [DEV_W-1:0]   dev_r, dev_nxt;
  logic [LINES_W-1:0] lines_r, lines_nxt;
  logic [SLOT_COUNT-1:0] written_r;

  // Result registers.
  logic              send_valid_r, send_valid_nxt;
  logic [BYTE_W-1:0] send_byte_r, send_byte_nxt;
  logic              sel_mem_r, sel_mem_nxt;
  logic              rd_ok_r;
  logic [BYTE_W-1:0] mem_q_r;

  // Store access.
  logic [BYTE_W-1:0] mem [DEPTH];
  logic              rd_en, wr_en, set_written;
  logic [SLOT_W-1:0] mem_slot;
  logic [CNT_W-1:0]  mem_cnt;
  logic [ADDR_W-1:0] mem_addr;
  logic [BYTE_W-1:0] load_off, save_off;

  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign load_off = rx_r - LOAD_BASE;
  assign save_off = rx_r - SAVE_BASE;
  assign mem_addr = ADDR_W'(mem_slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(mem_cnt);

  // Decode of the captured byte against the current mode.
  always_comb begin
    mode_nxt       = mode_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    dev_nxt        = dev_r;
    lines_nxt      = lines_r;
    send_valid_nxt = 1'b0;
    send_byte_nxt  = '0;
    sel_mem_nxt    = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    set_written    = 1'b0;
    mem_slot       = slot_r;
    mem_cnt        = cnt_r;
    case (mode_r)
      MODE_LOAD: begin
        if (cnt_inc >= CNT_W'(SLOT_BYTES)) begin
          mode_nxt = MODE_IDLE;
          cnt_nxt  = '0;
        end else begin
          cnt_nxt        = cnt_inc;
          mem_cnt        = cnt_inc;
          rd_en          = 1'b1;
          send_valid_nxt = 1'b1;
          sel_mem_nxt    = 1'b1;
        end
      end
      MODE_SAVE: begin
        wr_en          = 1'b1;
        send_valid_nxt = 1'b1;
        if (cnt_inc >= CNT_W'(SLOT_BYTES)) begin
          send_byte_nxt = ANS_SYNC;
          mode_nxt      = MODE_IDLE;
          cnt_nxt       = '0;
        end else begin
          send_byte_nxt = ANS_NEXT;
          cnt_nxt       = cnt_inc;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        if (rx_r >= SET_DEV_LO && rx_r <= SET_DEV_HI) begin
          dev_nxt        = rx_r[DEV_W-1:0];
          send_valid_nxt = 1'b1;
          send_byte_nxt  = ANS_DEV_OK;
        end else if (rx_r == CMD_GET_DEV) begin
          send_valid_nxt = 1'b1;
          send_byte_nxt  = (dev_r == '0) ? BYTE_W'(1) : BYTE_W'(dev_r);
        end else if (rx_r == CMD_SYNC) begin
          send_valid_nxt = 1'b1;
          send_byte_nxt  = ANS_SYNC;
        end else if (rx_r[7:4] == LINE_GROUP) begin
          lines_nxt = '0;
          if (rx_r >= CMD_LINE_LO && rx_r <= CMD_LINE_HI) begin
            lines_nxt = LINES_W'(1) << (rx_r[3:0] - 4'd1);
          end
        end else if (rx_r >= LOAD_BASE && rx_r < SAVE_BASE) begin
          if (load_off < BYTE_W'(SLOT_COUNT)) begin
            slot_nxt       = load_off[SLOT_W-1:0];
            cnt_nxt        = '0;
            mode_nxt       = MODE_LOAD;
            mem_slot       = load_off[SLOT_W-1:0];
            mem_cnt        = '0;
            rd_en          = 1'b1;
            send_valid_nxt = 1'b1;
            sel_mem_nxt    = 1'b1;
          end
        end else if (rx_r >= SAVE_BASE && rx_r < SAVE_END) begin
          if (save_off < BYTE_W'(SLOT_COUNT)) begin
            slot_nxt       = save_off[SLOT_W-1:0];
            cnt_nxt        = '0;
            mode_nxt       = MODE_SAVE;
            mem_slot       = save_off[SLOT_W-1:0];
            set_written    = 1'b1;
            send_valid_nxt = 1'b1;
            send_byte_nxt  = ANS_NEXT;
          end
        end
      end
    endcase
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rx_r <= in_rx_byte;
    end
  end

  // Control state; a slot is marked written when its save begins, and a
  // save always runs to its last byte before the next load can start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      slot_r    <= '0;
      cnt_r     <= '0;
      dev_r     <= '0;
      lines_r   <= '0;
      written_r <= '0;
    end else if (cmd.exec) begin
      mode_r  <= mode_nxt;
      slot_r  <= slot_nxt;
      cnt_r   <= cnt_nxt;
      dev_r   <= dev_nxt;
      lines_r <= lines_nxt;
      if (set_written) begin
        written_r[mem_slot] <= 1'b1;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      send_valid_r <= send_valid_nxt;
      send_byte_r  <= send_byte_nxt;
      sel_mem_r    <= sel_mem_nxt;
      if (rd_en) begin
        rd_ok_r <= written_r[mem_slot];
      end
    end
  end

  // Slot store: one access per item, registered read data.
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[mem_addr] <= rx_r;
    end
    if (cmd.exec && rd_en) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  // A slot never saved since reset reads as zero.
  assign out_send_valid = send_valid_r;
  assign out_send_byte  = sel_mem_r ? (rd_ok_r ? mem_q_r : '0) : send_byte_r;
  assign out_lines      = lines_r;

endmodule

// ===== hw/rtl/slot_store_command_responder.sv =====
// Top level of the slot store command responder.
// An accepted item is captured, then executed with its results registered, and its result is
// strobed on out_valid in the response state; it is taken at the edge that ends that state.
// Items do not overlap: capture, one slot store access and the response finish before the next item.
// Reset is synchronous and active low; it returns to idle and clears the lines, the device
// type and the per-slot written flags, so every slot reads as zero with no clearing pass.
// The receiver cannot stall: out_valid is high for exactly one cycle per item.
module slot_store_command_responder #(
  parameter int SLOT_BYTES = ssr_pkg::SLOT_BYTES_DEF,
  parameter int SLOT_COUNT = ssr_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ssr_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                         out_valid,
  output logic                         out_send_valid,
  output logic [ssr_pkg::BYTE_W-1:0]   out_send_byte,
  output logic [ssr_pkg::LINES_W-1:0]  out_lines
);
  import ssr_pkg::*;

  ctl_cmd_t cmd;

  // Sequencer.
  ssr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Decode, state and slot store.
  ssr_datapath #(
    .SLOT_BYTES (SLOT_BYTES),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_rx_byte     (in_rx_byte),
    .out_send_valid (out_send_valid),
    .out_send_byte  (out_send_byte),
    .out_lines      (out_lines)
  );

endmodule

// ===== bench/slot_store_checker.sv =====
// Checker that predicts and compares the results of the slot store command responder.
module slot_store_checker #(
  parameter int SLOT_BYTES = ssr_pkg::SLOT_BYTES_DEF,
  parameter int SLOT_COUNT = ssr_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [ssr_pkg::BYTE_W-1:0]  in_rx_byte,
  input  logic                        out_valid,
  input  logic                        out_send_valid,
  input  logic [ssr_pkg::BYTE_W-1:0]  out_send_byte,
  input  logic [ssr_pkg::LINES_W-1:0] out_lines,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssr_pkg::*;

  typedef struct packed {
    logic               send_valid;
    logic [BYTE_W-1:0]  send_byte;
    logic [LINES_W-1:0] lines;
  } reply_t;

  // Shadow state of the responder.
  mode_t              xfer_mode;
  logic [5:0]         cur_slot;
  logic [8:0]         cur_count;
  logic [DEV_W-1:0]   dev_type;
  logic [LINES_W-1:0] line_bits;
  logic [BYTE_W-1:0]  slot_image [SLOT_COUNT*SLOT_BYTES];

  reply_t expected_replies [$];
  reply_t oldest;

  // Works out the reply to one received byte and advances the shadow state.
  function automatic reply_t respond_to_byte(input logic [BYTE_W-1:0] b);
    reply_t r;
    int     slot_num;
    r = '0;
    if (xfer_mode == MODE_LOAD) begin
      cur_count = cur_count + 9'd1;
      if (cur_count >= SLOT_BYTES) begin
        xfer_mode = MODE_IDLE;
        cur_count = '0;
      end else begin
        r.send_valid = 1'b1;
        r.send_byte = slot_image[cur_slot * SLOT_BYTES + cur_count];
      end
    end else if (xfer_mode == MODE_SAVE) begin
      slot_image[cur_slot * SLOT_BYTES + cur_count] = b;
      cur_count = cur_count + 9'd1;
      r.send_valid = 1'b1;
      if (cur_count >= SLOT_BYTES) begin
        r.send_byte = ANS_SYNC;
        xfer_mode = MODE_IDLE;
        cur_count = '0;
      end else begin
        r.send_byte = ANS_NEXT;
      end
    end else begin
      xfer_mode = MODE_IDLE;
      if (b >= SET_DEV_LO && b <= SET_DEV_HI) begin
        dev_type = b[DEV_W-1:0];
        r.send_valid = 1'b1;
        r.send_byte = ANS_DEV_OK;
      end else if (b == CMD_GET_DEV) begin
        r.send_valid = 1'b1;
        r.send_byte = (dev_type == '0) ? 8'd1 : BYTE_W'(dev_type);
      end else if (b == CMD_SYNC) begin
        r.send_valid = 1'b1;
        r.send_byte = ANS_SYNC;
      end else if (b[7:4] == LINE_GROUP) begin
        // Any code in the line group clears all lines first.
        line_bits = '0;
        if (b >= CMD_LINE_LO && b <= CMD_LINE_HI)
          line_bits = LINES_W'(1) << (b - CMD_LINE_LO);
      end else if (b >= LOAD_BASE && b < SAVE_BASE) begin
        slot_num = int'(b - LOAD_BASE);
        if (slot_num < SLOT_COUNT) begin
          cur_slot = 6'(slot_num);
          cur_count = '0;
          xfer_mode = MODE_LOAD;
          r.send_valid = 1'b1;
          r.send_byte = slot_image[slot_num * SLOT_BYTES];
        end
      end else if (b >= SAVE_BASE && b < SAVE_END) begin
        slot_num = int'(b - SAVE_BASE);
        if (slot_num < SLOT_COUNT) begin
          cur_slot = 6'(slot_num);
          cur_count = '0;
          xfer_mode = MODE_SAVE;
          r.send_valid = 1'b1;
          r.send_byte = ANS_NEXT;
        end
      end
    end
    r.lines = line_bits;
    return r;
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  // Results are compared before the item of the same edge is predicted, since a
  // result always belongs to an item accepted at an earlier edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      xfer_mode = MODE_IDLE;
      cur_slot = '0;
      cur_count = '0;
      dev_type = '0;
      line_bits = '0;
      for (int i = 0; i < SLOT_COUNT * SLOT_BYTES; i++)
        slot_image[i] = '0;
      expected_replies.delete();
    end else begin
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: result expected none, actual send_valid %b send_byte %h lines %h",
                   $time, out_send_valid, out_send_byte, out_lines);
          mismatches = mismatches + 1;
        end else begin
          oldest = expected_replies.pop_front();
          if (out_send_valid !== oldest.send_valid) begin
            $display("%0t: send_valid expected %b actual %b",
                     $time, oldest.send_valid, out_send_valid);
            mismatches = mismatches + 1;
          end
          if (out_send_byte !== oldest.send_byte) begin
            $display("%0t: send_byte expected %h actual %h",
                     $time, oldest.send_byte, out_send_byte);
            mismatches = mismatches + 1;
          end
          if (out_lines !== oldest.lines) begin
            $display("%0t: lines expected %h actual %h", $time, oldest.lines, out_lines);
            mismatches = mismatches + 1;
          end
        end
      end
      if (start && !busy)
        expected_replies.push_back(respond_to_byte(in_rx_byte));
    end
    outstanding = expected_replies.size();
  end

endmodule

// ===== bench/slot_store_command_responder_test.sv =====
// Top of the testbench: stimulus for the slot store command responder and the verdict.
module slot_store_command_responder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssr_pkg::*;

  localparam int SLOT_BYTES  = SLOT_BYTES_DEF;
  localparam int SLOT_COUNT  = SLOT_COUNT_DEF;
  localparam int ITEM_TARGET = 1600;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 8;

  // Command codes that the package does not name.
  localparam logic [BYTE_W-1:0] LINE_CLEAR = 8'h10;
  localparam logic [BYTE_W-1:0] LINE_LAST  = 8'h1F;
  localparam logic [BYTE_W-1:0] NO_OP_CODES [8] =
    '{8'h00, 8'h05, 8'h0A, 8'h0C, 8'h0F, 8'h80, 8'hC3, 8'hFF};

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [BYTE_W-1:0]  in_rx_byte;
  logic               out_valid;
  logic               out_send_valid;
  logic [BYTE_W-1:0]  out_send_byte;
  logic [LINES_W-1:0] out_lines;
  int                 mismatches;
  int                 outstanding;
  int                 cycles = 0;
  int                 items_sent = 0;
  bit                 steady = 1'b0;
  int                 saved_slots [$];

  slot_store_command_responder #(
    .SLOT_BYTES(SLOT_BYTES),
    .SLOT_COUNT(SLOT_COUNT)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_send_valid(out_send_valid),
    .out_send_byte (out_send_byte),
    .out_lines     (out_lines)
  );

  slot_store_checker #(
    .SLOT_BYTES(SLOT_BYTES),
    .SLOT_COUNT(SLOT_COUNT)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_send_valid(out_send_valid),
    .out_send_byte (out_send_byte),
    .out_lines     (out_lines),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the handshake hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Holds start low for the given number of cycles.
  task automatic hold_off(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Offers one item and waits until the block takes it. Start stays high afterwards,
  // so back-to-back items never lower and raise it in the same step.
  task automatic send_item(input logic [BYTE_W-1:0] b, input bit tally);
    if (!steady) hold_off(pick_gap());
    @(negedge clk);
    start <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (busy);
    if (tally) items_sent++;
  endtask

  // A full save of one slot; with extremes set, the first two bytes of every four are 00 and FF.
  task automatic save_slot(input int slot_num, input bit extremes);
    logic [BYTE_W-1:0] d;
    send_item(BYTE_W'(SAVE_BASE + slot_num), 1'b1);
    for (int i = 0; i < SLOT_BYTES; i++) begin
      d = BYTE_W'($urandom_range(0, 255));
      if (extremes && (i % 4) < 2) d = (i % 4 == 0) ? 8'h00 : 8'hFF;
      send_item(d, 1'b1);
    end
    saved_slots.push_back(slot_num);
  endtask

  // A full load of one slot; the pacing byte values are random.
  task automatic load_slot(input int slot_num);
    send_item(BYTE_W'(LOAD_BASE + slot_num), 1'b1);
    for (int i = 0; i < SLOT_BYTES; i++)
      send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // One idle command that never starts a transfer; ignored codes are not tallied.
  task automatic send_idle_command();
    logic [BYTE_W-1:0] b;
    bit                counts;
    counts = 1'b1;
    case ($urandom_range(0, 5))
      0: b = BYTE_W'($urandom_range(SET_DEV_LO, SET_DEV_HI));
      1: b = CMD_GET_DEV;
      2: b = CMD_SYNC;
      3: b = BYTE_W'($urandom_range(LINE_CLEAR, LINE_LAST));
      default: begin
        b = $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, LINE_LAST))
                                 : BYTE_W'($urandom_range(SAVE_END, 8'hFF));
        counts = (b >= SET_DEV_LO && b <= CMD_GET_DEV) || b == CMD_SYNC ||
                 b[7:4] == LINE_GROUP;
      end
    endcase
    send_item(b, counts);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_rx_byte = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ignored codes, device type before and after setting, sync, lines.
    send_item(CMD_GET_DEV, 1'b1);
    foreach (NO_OP_CODES[i]) send_item(NO_OP_CODES[i], 1'b0);
    for (logic [BYTE_W-1:0] d = SET_DEV_LO; d <= SET_DEV_HI; d++) begin
      send_item(d, 1'b1);
      send_item(CMD_GET_DEV, 1'b1);
    end
    send_item(CMD_SYNC, 1'b1);
    send_item(CMD_LINE_LO, 1'b1);
    send_item(CMD_LINE_HI, 1'b1);
    send_item(LINE_CLEAR, 1'b1);
    send_item(BYTE_W'(CMD_LINE_LO + 4), 1'b1);
    send_item(LINE_LAST, 1'b1);
    send_item(BYTE_W'(CMD_LINE_HI + 1), 1'b1);

    // Transfers at the extreme slots: a never-written slot reads as zero.
    load_slot(0);
    save_slot(SLOT_COUNT - 1, 1'b1);
    load_slot(SLOT_COUNT - 1);

    // Random part: mostly whole transfers with random content, the rest idle commands.
    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: save_slot($urandom_range(0, SLOT_COUNT - 1), $urandom_range(0, 3) == 0);
        4, 5, 6: begin
          if (saved_slots.size() > 0 && $urandom_range(0, 3) != 0)
            load_slot(saved_slots[$urandom_range(0, saved_slots.size() - 1)]);
          else
            load_slot($urandom_range(0, SLOT_COUNT - 1));
        end
        default: repeat ($urandom_range(1, 12)) send_idle_command();
      endcase
    end

    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
